### design/mtra_pkg.sv
// ----------------------------------------------------------------------------
// mtra_pkg
// Shared types, codes and helpers for the memory-type range allocator.
// ----------------------------------------------------------------------------
package mtra_pkg;

  localparam int NUM_ENTRIES   = 8;
  localparam int MAX_ADDR_BITS = 52;
  localparam int MIN_ADDR_BITS = 32;

  localparam int SLOT_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);

  localparam int ADDR_W  = 52;
  localparam int END_W   = ADDR_W + 1;
  localparam int TYPE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int OSLOT_W = 3;
  localparam int WORD_W  = 64;
  localparam int PAGE_W  = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int ENT_FLD_W  = 4;
  localparam int PAB_FLD_W  = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDR   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DISABLED = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVL_UC   = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVL_UNDEF = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd4;

  // memory type codes
  localparam logic [TYPE_W-1:0] MT_UC = 8'd0;
  localparam logic [TYPE_W-1:0] MT_WT = 8'd4;
  localparam logic [TYPE_W-1:0] MT_WB = 8'd6;

  localparam int ENT_RESET  = 8;
  localparam int PADDR_RESET = 32;

  // request token that walks down the row of cells
  typedef struct packed {
    logic                vld;
    logic [ADDR_W-1:0]   addr;
    logic [END_W-1:0]    req_end;
    logic [TYPE_W-1:0]   mtype;
    logic [ADDR_W-1:0]   base_m;
    logic [ADDR_W-1:0]   mask_m;
    logic [STAT_W-1:0]   status;
    logic                stop;
    logic                has_free;
    logic [SLOT_W-1:0]   free_slot;
  } token_t;

  // slot write broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   base;
    logic [TYPE_W-1:0]   mtype;
    logic [ADDR_W-1:0]   mask;
  } wr_t;

  // masks and slot count derived from the configuration
  typedef struct packed {
    logic [END_W-1:0]    or_hi;     // bits at and above P set
    logic [ADDR_W-1:0]   and_mask;  // bits 12 .. P-1 set
    logic [CNT_W-1:0]    n_eff;
  } geom_t;

  function automatic logic [CNT_W-1:0] eff_entries(input logic [ENT_FLD_W-1:0] v);
    logic [CNT_W-1:0] n;
    if (32'(v) > NUM_ENTRIES) n = CNT_W'(NUM_ENTRIES);
    else n = CNT_W'(v);
    return n;
  endfunction

  function automatic logic [PAB_FLD_W-1:0] eff_bits(input logic [PAB_FLD_W-1:0] v);
    logic [PAB_FLD_W-1:0] p;
    p = v;
    if (32'(p) < MIN_ADDR_BITS) p = PAB_FLD_W'(MIN_ADDR_BITS);
    if (32'(p) > MAX_ADDR_BITS) p = PAB_FLD_W'(MAX_ADDR_BITS);
    return p;
  endfunction

  function automatic logic [END_W-1:0] or_mask_of(input logic [PAB_FLD_W-1:0] p);
    logic [END_W-1:0] m;
    for (int b = 0; b < END_W; b++) m[b] = (b >= int'(p));
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] and_mask_of(input logic [PAB_FLD_W-1:0] p);
    logic [ADDR_W-1:0] m;
    for (int b = 0; b < ADDR_W; b++) m[b] = (b >= PAGE_W) && (b < int'(p));
    return m;
  endfunction

endpackage

### design/mtra_cfg_if.sv
// ----------------------------------------------------------------------------
// mtra_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface mtra_cfg_if
  import mtra_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/mtra_req_if.sv
// ----------------------------------------------------------------------------
// mtra_req_if
// Request channel: region base, size and memory type.
// ----------------------------------------------------------------------------
interface mtra_req_if
  import mtra_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] req_base;
  logic [ADDR_W-1:0] req_size;
  logic [TYPE_W-1:0] mem_type;

  modport source (output valid, output req_base, output req_size, output mem_type,
                  input ready);
  modport sink   (input valid, input req_base, input req_size, input mem_type,
                  output ready);
endinterface

### design/mtra_rsp_if.sv
// ----------------------------------------------------------------------------
// mtra_rsp_if
// Response channel: status, slot and the base and mask register words.
// ----------------------------------------------------------------------------
interface mtra_rsp_if
  import mtra_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [OSLOT_W-1:0] slot;
  logic [WORD_W-1:0]  base_word;
  logic [WORD_W-1:0]  mask_word;

  modport source (output valid, output status, output slot, output base_word,
                  output mask_word, input ready);
  modport sink   (input valid, input status, input slot, input base_word,
                  input mask_word, output ready);
endinterface

### design/mtra_cell.sv
// ----------------------------------------------------------------------------
// mtra_cell
// One range slot: holds base, type, mask and valid, checks the passing
// request token for overlap and hands the updated token to its neighbor.
// ----------------------------------------------------------------------------
module mtra_cell
  import mtra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [SLOT_W-1:0] cell_idx,
  input  geom_t             geom,
  input  wr_t               wr,
  input  token_t            tok_in,
  output token_t            tok_out
);

  logic [ADDR_W-1:0] r_base;
  logic [TYPE_W-1:0] r_type;
  logic [ADDR_W-1:0] r_mask;
  logic              r_valid;

  logic [END_W-1:0]  neg_size;
  logic [END_W:0]    lhs;
  logic [END_W:0]    rhs;
  logic              overlap;
  logic              in_range;
  logic              pair_ok;
  token_t            tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (wr.en && wr.slot == cell_idx) begin
      r_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == cell_idx) begin
      r_base <= wr.base;
      r_type <= wr.mtype;
      r_mask <= wr.mask;
    end
  end

  // range end = base + 2^53 - neg_size; compare without forming it
  always_comb begin
    neg_size = geom.or_hi | {1'b0, r_mask};
    neg_size[PAGE_W-1:0] = '0;
    lhs = {2'b10, r_base};
    rhs = {2'b00, tok_in.addr} + {1'b0, neg_size};
    overlap = ({1'b0, r_base} < tok_in.req_end) && (lhs > rhs);
    in_range = CNT_W'(cell_idx) < geom.n_eff;
    pair_ok = (r_type == MT_WB && tok_in.mtype == MT_WT) ||
              (r_type == MT_WT && tok_in.mtype == MT_WB);
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && !tok_in.stop && in_range) begin
      if (r_valid) begin
        if (overlap && r_type != tok_in.mtype && !pair_ok) begin
          tok_next.stop   = 1'b1;
          tok_next.status = (r_type == MT_UC) ? ST_OVL_UC : ST_OVL_UNDEF;
        end
      end else if (!tok_in.has_free) begin
        tok_next.has_free  = 1'b1;
        tok_next.free_slot = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

### design/memory_type_range_allocator_top.sv
// ----------------------------------------------------------------------------
// memory_type_range_allocator_top
// Variable memory-type range table with overlap checking and slot allocation.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : write channel, always ready. Index 0 enable, 1 entries in use,
//         2 physical address bits. Write only while no request is in flight.
//   req : one beat per request (base, size, memory type).
//   rsp : one beat per request (status, slot, base word, mask word).
// Flow: a request beat is latched in the entry stage, then walks the row of
//   eight slot cells one cell per cycle while no response stalls, then the
//   verdict is registered and the chosen slot written. A new request is taken
//   once the row is empty, which it is when the response registers; a new
//   request is not taken while another is still in the row.
// Stall: while a response waits and rsp.ready is low, the next request may
//   still be accepted; it holds in the row until the response is taken.
// Reset: all slots invalid, enable 0, eight entries, 32 address bits; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module memory_type_range_allocator_top
  import mtra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mtra_cfg_if.sink   cfg,
  mtra_req_if.sink   req,
  mtra_rsp_if.source rsp
);

  logic   enable;
  geom_t  geom;
  token_t head;
  token_t chain [NUM_ENTRIES+1];
  logic   [NUM_ENTRIES:0] busy_vec;
  logic   advance;
  logic   req_take;
  wr_t    wr;
  token_t last;
  logic [STAT_W-1:0] fin_status;

  logic               rsp_valid;
  logic [STAT_W-1:0]  rsp_status;
  logic [OSLOT_W-1:0] rsp_slot;
  logic [WORD_W-1:0]  rsp_base;
  logic [WORD_W-1:0]  rsp_mask;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      geom.n_eff    <= eff_entries(ENT_FLD_W'(ENT_RESET));
      geom.or_hi    <= or_mask_of(PAB_FLD_W'(PADDR_RESET));
      geom.and_mask <= and_mask_of(PAB_FLD_W'(PADDR_RESET));
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ENABLE:  enable <= cfg.data[0];
        CFG_ENTRIES: geom.n_eff <= eff_entries(cfg.data[ENT_FLD_W-1:0]);
        CFG_PADDR: begin
          geom.or_hi    <= or_mask_of(eff_bits(cfg.data[PAB_FLD_W-1:0]));
          geom.and_mask <= and_mask_of(eff_bits(cfg.data[PAB_FLD_W-1:0]));
        end
        default: ;
      endcase
    end
  end

  // row occupancy
  always_comb begin
    for (int i = 0; i <= NUM_ENTRIES; i++) busy_vec[i] = chain[i].vld;
  end

  assign req.ready = ~|busy_vec;
  assign req_take  = req.valid && req.ready;
  assign advance   = !rsp_valid || rsp.ready;

  // entry stage: latch the request and its masked words
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (req_take) begin
      head.vld       <= 1'b1;
      head.addr      <= req.req_base;
      head.req_end   <= {1'b0, req.req_base} + {1'b0, req.req_size};
      head.mtype     <= req.mem_type;
      head.base_m    <= req.req_base & geom.and_mask;
      head.mask_m    <= (ADDR_W'(0) - req.req_size) & geom.and_mask;
      head.status    <= enable ? ST_OK : ST_DISABLED;
      head.stop      <= !enable;
      head.has_free  <= 1'b0;
      head.free_slot <= '0;
    end else if (advance) begin
      head.vld <= 1'b0;
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    mtra_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_idx (SLOT_W'(g)),
      .geom     (geom),
      .wr       (wr),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  // verdict and slot write
  assign last = chain[NUM_ENTRIES];

  always_comb begin
    fin_status = last.status;
    if (last.status == ST_OK && !last.has_free) fin_status = ST_NO_FREE;
    wr.en    = advance && last.vld && fin_status == ST_OK;
    wr.slot  = last.free_slot;
    wr.base  = last.base_m;
    wr.mtype = last.mtype;
    wr.mask  = last.mask_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance && last.vld) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last.vld) begin
      rsp_status <= fin_status;
      if (fin_status == ST_OK) begin
        rsp_slot <= OSLOT_W'(last.free_slot);
        rsp_base <= {12'b0, last.base_m[ADDR_W-1:TYPE_W], last.mtype};
        rsp_mask <= {12'b0, last.mask_m[ADDR_W-1:PAGE_W], 1'b1, 11'b0};
      end else begin
        rsp_slot <= '0;
        rsp_base <= '0;
        rsp_mask <= '0;
      end
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.slot      = rsp_slot;
  assign rsp.base_word = rsp_base;
  assign rsp.mask_word = rsp_mask;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the memory-type range allocator end to end. Requests are offered
// with random gaps and response stalls, and every response beat is compared
// against a local model of the range table, the overlap rules and the
// base and mask word encoding.
// ----------------------------------------------------------------------------
module tb;
  import mtra_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [TYPE_W-1:0] mtype;
  } range_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [OSLOT_W-1:0] slot;
    logic [WORD_W-1:0]  base_word;
    logic [WORD_W-1:0]  mask_word;
  } range_rsp_t;

  localparam logic [TYPE_W-1:0] MT_WC = 8'd1;
  localparam logic [TYPE_W-1:0] MT_WP = 8'd5;
  localparam logic [ADDR_W-1:0] ADDR_ALL = '1;
  localparam logic [WORD_W-1:0] PAGE_OFS = 64'hfff;
  localparam logic [WORD_W-1:0] MASK_VALID = 64'h800;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 216;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_PHASE = 4;
  localparam int MAX_PRINTS = 40;

  // per-phase register values; some carry junk above the field width
  int phase_en  [NUM_PHASES] = '{1, 1, 1, 62, 1, 63, 1, 1};
  int phase_ent [NUM_PHASES] = '{8, 5, 8, 3, 15, 2, 63, 6};
  int phase_pab [NUM_PHASES] = '{32, 40, 52, 45, 63, 0, 36, 51};

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtra_cfg_if cfg_if ();
  mtra_req_if req_if ();
  mtra_rsp_if rsp_if ();

  memory_type_range_allocator_top u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  // range table and configuration as the block should hold them
  logic                 mdl_enable;
  logic [ENT_FLD_W-1:0] mdl_entries;
  logic [PAB_FLD_W-1:0] mdl_paddr;
  logic [ADDR_W-1:0]    slot_base [NUM_ENTRIES];
  logic [TYPE_W-1:0]    slot_type [NUM_ENTRIES];
  logic [ADDR_W-1:0]    slot_mask [NUM_ENTRIES];
  logic                 slot_used [NUM_ENTRIES];

  range_req_t pending_req_q [$];
  range_rsp_t alloc_rsp_q [$];
  range_req_t drv_req;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_done;
  int hold_left;
  int err_count = 0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_PRINTS) begin
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    end
    err_count++;
  endtask

  // Check the request against every live slot below the entry count, then claim the first free one there.
  function automatic range_rsp_t predict_alloc(input range_req_t r);
    range_rsp_t res;
    logic [63:0] full, and_m, or_m, req_end, r_start, r_size;
    logic [STAT_W-1:0] st;
    logic [TYPE_W-1:0] t;
    int p, n, free_idx;
    res = '0;
    if (!mdl_enable) begin
      res.status = ST_DISABLED;
      return res;
    end
    p = (mdl_paddr < MIN_ADDR_BITS) ? MIN_ADDR_BITS : int'(mdl_paddr);
    if (p > MAX_ADDR_BITS) p = MAX_ADDR_BITS;
    n = (mdl_entries > NUM_ENTRIES) ? NUM_ENTRIES : int'(mdl_entries);
    full = (64'd1 << p) - 64'd1;
    and_m = full & ~PAGE_OFS;
    or_m = ~full;
    req_end = 64'(r.base) + 64'(r.size);
    free_idx = -1;
    st = ST_OK;
    for (int i = 0; i < n && st == ST_OK; i++) begin
      if (slot_used[i]) begin
        t = slot_type[i];
        r_start = 64'(slot_base[i]);
        r_size = 64'd0 - ((or_m | 64'(slot_mask[i])) & ~PAGE_OFS);
        if (r_start < req_end && r_start + r_size > 64'(r.base) && t != r.mtype) begin
          if (t == MT_UC) begin
            st = ST_OVL_UC;
          end else if (!((t == MT_WB && r.mtype == MT_WT) ||
                         (t == MT_WT && r.mtype == MT_WB))) begin
            st = ST_OVL_UNDEF;
          end
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (st == ST_OK && free_idx < 0) st = ST_NO_FREE;
    if (st != ST_OK) begin
      res.status = st;
      return res;
    end
    slot_base[free_idx] = ADDR_W'(64'(r.base) & and_m);
    slot_type[free_idx] = r.mtype;
    slot_mask[free_idx] = ADDR_W'((64'd0 - 64'(r.size)) & and_m);
    slot_used[free_idx] = 1'b1;
    res.status = ST_OK;
    res.slot = OSLOT_W'(free_idx);
    res.base_word = (64'(r.base) & and_m) | 64'(r.mtype);
    res.mask_word = ((64'd0 - 64'(r.size)) & and_m) | MASK_VALID;
    return res;
  endfunction

  // Mostly requests aimed around live ranges with common types; some noise.
  function automatic range_req_t rand_req();
    range_req_t r;
    logic [63:0] span, delta;
    int j;
    r.base = ADDR_W'({$urandom, $urandom});
    r.size = ADDR_W'({$urandom, $urandom});
    r.mtype = TYPE_W'($urandom);
    if ($urandom_range(99) < 15) return r;
    j = $urandom_range(NUM_ENTRIES - 1);
    if (slot_used[j] && $urandom_range(3) != 0) begin
      span = 64'd1 << $urandom_range(8, 34);
      delta = {$urandom, $urandom} % span;
      if ($urandom_range(1)) r.base = ADDR_W'(64'(slot_base[j]) + delta);
      else r.base = ADDR_W'(64'(slot_base[j]) - delta);
    end else begin
      r.base = ADDR_W'({$urandom, $urandom} >> $urandom_range(12, 30));
    end
    case ($urandom_range(5))
      0: r.size = '0;
      1: r.size = ADDR_W'($urandom_range(1, 64)) << PAGE_W;
      2: r.size = ADDR_W'($urandom);
      3: r.size = ADDR_W'($urandom_range(1, 4095));
      default: r.size = ADDR_W'({$urandom, $urandom} >> $urandom_range(12, 40));
    endcase
    case ($urandom_range(8))
      0: r.mtype = MT_UC;
      1: r.mtype = MT_WC;
      2, 3: r.mtype = MT_WT;
      4: r.mtype = MT_WP;
      5, 6: r.mtype = MT_WB;
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_req(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                           input logic [TYPE_W-1:0] mtype);
    while (pending_req_q.size() >= 4) @(negedge clk);
    pending_req_q.push_back(range_req_t'{base: base, size: size, mtype: mtype});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_req_q.size() != 0 || req_if.valid || alloc_rsp_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_ENABLE:  mdl_enable = val[0];
      CFG_ENTRIES: mdl_entries = val[ENT_FLD_W-1:0];
      CFG_PADDR:   mdl_paddr = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // request driver: predict on every accepted beat, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) alloc_rsp_q.push_back(predict_alloc(drv_req));
      if (!req_if.valid || req_if.ready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          drv_req = pending_req_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.req_base <= drv_req.base;
          req_if.req_size <= drv_req.size;
          req_if.mem_type <= drv_req.mtype;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready: one long hold-off when armed, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // response monitor
  always @(posedge clk) begin
    range_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (alloc_rsp_q.size() == 0) begin
        report_mismatch("beat with nothing outstanding, status", rsp_if.status, 0);
      end else begin
        want = alloc_rsp_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.slot !== want.slot)
          report_mismatch("slot", rsp_if.slot, want.slot);
        if (rsp_if.base_word !== want.base_word)
          report_mismatch("base_word", rsp_if.base_word, want.base_word);
        if (rsp_if.mask_word !== want.mask_word)
          report_mismatch("mask_word", rsp_if.mask_word, want.mask_word);
      end
    end
  end

  initial begin
    range_req_t r;
    int mode;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ENABLE;
    cfg_if.data = '0;
    req_if.valid = 1'b0;
    req_if.req_base = '0;
    req_if.req_size = '0;
    req_if.mem_type = '0;
    rsp_if.ready = 1'b0;
    mdl_enable = 1'b0;
    mdl_entries = ENT_FLD_W'(ENT_RESET);
    mdl_paddr = PAB_FLD_W'(PADDR_RESET);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      slot_base[i] = '0;
      slot_type[i] = '0;
      slot_mask[i] = '0;
      slot_used[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled out of reset
    queue_req(ADDR_ALL, ADDR_ALL, 8'hff);
    queue_req('0, '0, MT_UC);
    drain();

    // one slot, address width below the floor
    write_reg(CFG_ENABLE, 6'd1);
    write_reg(CFG_ENTRIES, 6'd1);
    write_reg(CFG_PADDR, 6'd0);
    queue_req(52'h1000_0000, 52'h1000_0000, MT_WB);
    queue_req(52'h1800_0000, 52'h1000, MT_WB);
    queue_req(52'h1800_0000, 52'h1000, MT_WT);
    queue_req(52'h1800_0000, 52'h1000, MT_UC);
    queue_req(52'h1800_0000, 52'h1000, MT_WC);
    queue_req(52'h1800_0000, '0, MT_WP);
    queue_req(52'h4000_0000, 52'h1000, MT_WP);
    drain();

    // slot count and address width above their ceilings
    write_reg(CFG_ENTRIES, 6'd15);
    write_reg(CFG_PADDR, 6'd63);
    queue_req(52'h8000_0000, 52'h1000, MT_UC);
    queue_req(52'h8000_0800, 52'h10, MT_WB);
    queue_req(ADDR_ALL, ADDR_ALL, 8'hff);
    queue_req(52'h2000, 52'h1000, MT_WT);
    queue_req(52'h1400_0000, 52'h2000, MT_WT);
    queue_req(52'h3000, 52'h1000, MT_WB);
    drain();

    // no slots at all, then upper slots hidden but kept
    write_reg(CFG_ENTRIES, 6'd0);
    queue_req(52'h5000_0000, 52'h1000, MT_WB);
    drain();
    write_reg(CFG_ENTRIES, 6'd2);
    queue_req(52'h2000, 52'h1000, MT_UC);
    queue_req(ADDR_ALL, '0, MT_WB);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_ENABLE, CFG_DATA_W'(phase_en[ph]));
      write_reg(CFG_ENTRIES, CFG_DATA_W'(phase_ent[ph]));
      write_reg(CFG_PADDR, CFG_DATA_W'(phase_pab[ph]));
      mode = ph % 4;
      snd_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 20 : 0;
      rcv_stall_pct = (mode == 2) ? 79 : (mode == 3) ? 20 : 0;
      if (ph == HOLD_PHASE) hold_arm = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = rand_req();
        queue_req(r.base, r.size, r.mtype);
      end
      // hold the sender until every response is back
      drain();
    end

    repeat (20) @(negedge clk);
    if (err_count == 0 && alloc_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
